// File: rtl/mvpm_pkg.sv
// shared types and constants of the multi-voice pcm mixer
package mvpm_pkg;

	localparam int VOICES_DEF = 32;
	localparam int MAX_SAMPLES_DEF = 4096;

	// command codes
	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_LOAD = 2'd1,
		CMD_STOP = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	// configuration register indexes
	localparam logic REG_FORMAT = 1'b0;
	localparam logic REG_ENABLE = 1'b1;

	localparam logic [15:0] GAIN_ONE = 16'h8000;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD_FIND,
		ST_LOAD_WRITE,
		ST_MIX_READ,
		ST_MIX_MUL,
		ST_MIX_ACC,
		ST_LOOP_READ,
		ST_LOOP_MUL,
		ST_LOOP_ACC,
		ST_FMT_MUL,
		ST_FMT_OUT,
		ST_OUT_WAIT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic in_take;
		logic load_first;
		logic load_write;
		logic loop_halt;
		logic mix_clear;
		logic mix_read;
		logic mix_mul;
		logic mix_acc;
		logic loop_read;
		logic loop_mul;
		logic loop_acc;
		logic fmt_mul;
		logic fmt_out;
	} ctl_t;

	// status from datapath to controller
	typedef struct packed {
		logic load_busy;
		logic voice_last;
	} sts_t;

endpackage

// File: rtl/mvpm_ctrl.sv
// sequencing state machine of the mixer
module mvpm_ctrl #(
	parameter int VOICES = mvpm_pkg::VOICES_DEF,
	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_cmd,
	input  logic               enabled,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  mvpm_pkg::sts_t     sts,
	output mvpm_pkg::ctl_t     ctl,
	output logic [VW-1:0]      voice
);

	mvpm_pkg::state_t state_q, state_d;
	logic [VW-1:0] voice_q, voice_d;
	logic out_valid_q, out_valid_d;
	logic take;

	assign take = in_valid && in_ready;
	assign voice = voice_q;
	assign out_valid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mvpm_pkg::ST_IDLE;
			voice_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			voice_q <= voice_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		voice_d = voice_q;
		out_valid_d = out_valid_q;
		if (out_valid_q && out_ready) out_valid_d = 1'b0;
		unique case (state_q)
			mvpm_pkg::ST_IDLE: begin
				voice_d = '0;
				if (take) begin
					if (in_cmd == mvpm_pkg::CMD_TICK) state_d = mvpm_pkg::ST_MIX_READ;
					else if (in_cmd == mvpm_pkg::CMD_LOAD && enabled)
						state_d = sts.load_busy ? mvpm_pkg::ST_LOAD_WRITE
							: mvpm_pkg::ST_LOAD_FIND;
				end
			end
			mvpm_pkg::ST_LOAD_FIND: state_d = mvpm_pkg::ST_LOAD_WRITE;
			mvpm_pkg::ST_LOAD_WRITE: state_d = mvpm_pkg::ST_IDLE;
			mvpm_pkg::ST_MIX_READ: state_d = mvpm_pkg::ST_MIX_MUL;
			mvpm_pkg::ST_MIX_MUL: state_d = mvpm_pkg::ST_MIX_ACC;
			mvpm_pkg::ST_MIX_ACC: begin
				if (sts.voice_last) state_d = mvpm_pkg::ST_LOOP_READ;
				else begin
					voice_d = voice_q + 1'b1;
					state_d = mvpm_pkg::ST_MIX_READ;
				end
			end
			mvpm_pkg::ST_LOOP_READ: state_d = mvpm_pkg::ST_LOOP_MUL;
			mvpm_pkg::ST_LOOP_MUL: state_d = mvpm_pkg::ST_LOOP_ACC;
			mvpm_pkg::ST_LOOP_ACC: state_d = mvpm_pkg::ST_FMT_MUL;
			mvpm_pkg::ST_FMT_MUL: state_d = mvpm_pkg::ST_OUT_WAIT;
			// hold until the previous result has left the output register
			mvpm_pkg::ST_OUT_WAIT: begin
				if (!out_valid_q || out_ready) state_d = mvpm_pkg::ST_FMT_OUT;
			end
			mvpm_pkg::ST_FMT_OUT: begin
				out_valid_d = 1'b1;
				state_d = mvpm_pkg::ST_IDLE;
			end
			default: state_d = mvpm_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl = '0;
		in_ready = (state_q == mvpm_pkg::ST_IDLE);
		unique case (state_q)
			mvpm_pkg::ST_IDLE: begin
				ctl.in_take = take;
				ctl.mix_clear = take && in_cmd == mvpm_pkg::CMD_TICK;
				ctl.loop_halt = take && in_cmd == mvpm_pkg::CMD_STOP && enabled;
			end
			mvpm_pkg::ST_LOAD_FIND: ctl.load_first = 1'b1;
			mvpm_pkg::ST_LOAD_WRITE: ctl.load_write = 1'b1;
			mvpm_pkg::ST_MIX_READ: ctl.mix_read = 1'b1;
			mvpm_pkg::ST_MIX_MUL: ctl.mix_mul = 1'b1;
			mvpm_pkg::ST_MIX_ACC: ctl.mix_acc = 1'b1;
			mvpm_pkg::ST_LOOP_READ: ctl.loop_read = 1'b1;
			mvpm_pkg::ST_LOOP_MUL: ctl.loop_mul = 1'b1;
			mvpm_pkg::ST_LOOP_ACC: ctl.loop_acc = 1'b1;
			mvpm_pkg::ST_FMT_MUL: ctl.fmt_mul = 1'b1;
			mvpm_pkg::ST_FMT_OUT: ctl.fmt_out = 1'b1;
			mvpm_pkg::ST_OUT_WAIT: ;
			default: ;
		endcase
	end

endmodule

// File: rtl/mvpm_dp.sv
// voice stores, load logic and multiply-accumulate of the mixer
module mvpm_dp #(
	parameter int VOICES = mvpm_pkg::VOICES_DEF,
	parameter int MAX_SAMPLES = mvpm_pkg::MAX_SAMPLES_DEF,
	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1,
	localparam int AW = $clog2(MAX_SAMPLES),
	localparam int LW = AW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mvpm_pkg::ctl_t       ctl,
	output mvpm_pkg::sts_t       sts,
	input  logic [VW-1:0]        voice,
	input  logic                 fmt32,
	input  logic signed [15:0]   in_sample,
	input  logic [15:0]          in_gain,
	input  logic                 in_loop,
	input  logic                 in_last,
	output logic [31:0]          result
);

	localparam logic [LW-1:0] MAXS = LW'(MAX_SAMPLES);

	// sample memories, one slot of 2^AW entries per voice
	logic signed [15:0] vmem [VOICES*(1 << AW)];
	logic signed [15:0] lmem [MAX_SAMPLES];
	logic signed [15:0] rd_s1;

	// per-voice registers
	logic [LW-1:0] vlen_q [VOICES];
	logic [LW-1:0] vcur_q [VOICES];
	logic [15:0]   vgain_q [VOICES];
	logic [VOICES-1:0] vact_q, vres_q;

	logic [LW-1:0] llen_q, lcur_q;
	logic [15:0] lgain_q;
	logic lact_q;

	logic busy_q, drop_q, toloop_q;
	logic [VW-1:0] tgt_q;
	logic [LW-1:0] cnt_q;
	logic [15:0] lgain_ld_q;

	// fields of the accepted item
	logic signed [15:0] in_smp_q;
	logic [15:0] in_gain_q;
	logic in_loop_q, in_last_q;

	logic signed [32:0] prod_s2;
	logic signed [37:0] acc_q;
	logic [62:0] fprod_q;
	logic fneg_q;
	logic [31:0] result_q;

	// first free slot search
	logic found;
	logic [VW-1:0] free_idx;
	always_comb begin
		found = 1'b0;
		free_idx = '0;
		for (int v = VOICES - 1; v >= 0; v--) begin
			if (!vact_q[v] && !vres_q[v]) begin
				found = 1'b1;
				free_idx = VW'(v);
			end
		end
	end

	logic [15:0] gsat;
	assign gsat = (in_gain_q > mvpm_pkg::GAIN_ONE) ? mvpm_pkg::GAIN_ONE : in_gain_q;

	logic [LW-1:0] cnt_inc;
	assign cnt_inc = (cnt_q < MAXS) ? cnt_q + 1'b1 : cnt_q;

	logic vcur_ok, lcur_ok;
	assign vcur_ok = vcur_q[voice] < MAXS;
	assign lcur_ok = lcur_q < MAXS;

	assign sts.load_busy = busy_q;
	assign sts.voice_last = (voice == VW'(VOICES - 1));

	// memory write and read
	always_ff @(posedge clk) begin
		if (ctl.load_write && !drop_q && cnt_q < MAXS) begin
			if (toloop_q) lmem[cnt_q[AW-1:0]] <= in_smp_q;
			else vmem[{tgt_q, cnt_q[AW-1:0]}] <= in_smp_q;
		end
		if (ctl.mix_read) rd_s1 <= vmem[{voice, vcur_q[voice][AW-1:0]}];
		else if (ctl.loop_read) rd_s1 <= lmem[lcur_q[AW-1:0]];
	end

	// multiply and format datapath
	logic signed [37:0] acc_sat;
	logic [30:0] mag;
	logic [62:0] rnd;
	always_comb begin
		acc_sat = acc_q;
		if (acc_q > 38'sd1073741824) acc_sat = 38'sd1073741824;
		if (acc_q < -38'sd1073741824) acc_sat = -38'sd1073741824;
		mag = acc_sat[37] ? 31'(-acc_sat) : 31'(acc_sat);
		rnd = fprod_q + (fmt32 ? 63'd0 : 63'd536870912);
	end

	always_ff @(posedge clk) begin
		if (ctl.mix_mul) prod_s2 <= (vact_q[voice] && vcur_ok)
			? rd_s1 * $signed({1'b0, vgain_q[voice]}) : 33'sd0;
		if (ctl.loop_mul) prod_s2 <= (lact_q && llen_q != '0 && lcur_ok)
			? rd_s1 * $signed({1'b0, lgain_q}) : 33'sd0;
		if (ctl.mix_clear) acc_q <= '0;
		else if (ctl.mix_acc || ctl.loop_acc) acc_q <= acc_q + 38'(prod_s2);
		if (ctl.fmt_mul) begin
			fprod_q <= 63'(mag) * (fmt32 ? 63'd2147483647 : 63'd32767);
			fneg_q <= acc_sat[37];
		end
		if (ctl.fmt_out) result_q <= fneg_q ? 32'(-rnd[62:30]) : rnd[61:30];
	end
	assign result = result_q;

	// voice and load control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vact_q <= '0;
			vres_q <= '0;
			for (int v = 0; v < VOICES; v++) begin
				vlen_q[v] <= '0;
				vcur_q[v] <= '0;
				vgain_q[v] <= '0;
			end
			llen_q <= '0;
			lcur_q <= '0;
			lgain_q <= '0;
			lact_q <= 1'b0;
			busy_q <= 1'b0;
			drop_q <= 1'b0;
			toloop_q <= 1'b0;
			tgt_q <= '0;
			cnt_q <= '0;
			lgain_ld_q <= '0;
			in_smp_q <= '0;
			in_gain_q <= '0;
			in_loop_q <= 1'b0;
			in_last_q <= 1'b0;
		end else begin
			// hold the fields of the transfer for the load steps
			if (ctl.in_take) begin
				in_smp_q <= in_sample;
				in_gain_q <= in_gain;
				in_loop_q <= in_loop;
				in_last_q <= in_last;
			end
			if (ctl.loop_halt) begin
				lact_q <= 1'b0;
				llen_q <= '0;
				lcur_q <= '0;
			end
			// first sample of a buffer
			if (ctl.load_first) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				lgain_ld_q <= gsat;
				toloop_q <= in_loop_q;
				if (gsat == '0) begin
					tgt_q <= '0;
					drop_q <= 1'b1;
				end else if (in_loop_q) begin
					tgt_q <= '0;
					drop_q <= 1'b0;
					lact_q <= 1'b0;
				end else if (found) begin
					tgt_q <= free_idx;
					drop_q <= 1'b0;
					vres_q[free_idx] <= 1'b1;
				end else begin
					tgt_q <= '0;
					drop_q <= 1'b1;
				end
			end
			// sample write and buffer close
			if (ctl.load_write) begin
				if (in_last_q) begin
					if (!drop_q) begin
						if (toloop_q) begin
							llen_q <= cnt_inc;
							lcur_q <= '0;
							lgain_q <= lgain_ld_q;
							lact_q <= 1'b1;
						end else begin
							vlen_q[tgt_q] <= cnt_inc;
							vcur_q[tgt_q] <= '0;
							vgain_q[tgt_q] <= lgain_ld_q;
							vact_q[tgt_q] <= 1'b1;
							vres_q[tgt_q] <= 1'b0;
						end
					end
					busy_q <= 1'b0;
					cnt_q <= '0;
					drop_q <= 1'b0;
					toloop_q <= 1'b0;
					tgt_q <= '0;
				end else cnt_q <= cnt_inc;
			end
			// cursor advance per voice
			if (ctl.mix_acc && vact_q[voice]) begin
				if (vcur_q[voice] + 1'b1 >= vlen_q[voice]) begin
					vact_q[voice] <= 1'b0;
					vcur_q[voice] <= '0;
				end else vcur_q[voice] <= vcur_q[voice] + 1'b1;
			end
			if (ctl.loop_acc && lact_q && llen_q != '0) begin
				lcur_q <= (lcur_q + 1'b1 >= llen_q) ? '0 : lcur_q + 1'b1;
			end
		end
	end

endmodule

// File: rtl/multi_voice_pcm_mixer.sv
// top level of the multi-voice pcm mixer
// A tick steps each voice and then the loop voice through one shared sample-memory
// read, multiply and accumulate, then through the clamp and format multiply, a wait
// for the output register to be free and the result write. A result that has not
// yet been taken holds a following tick at that wait. A load sample passes through
// the find and write steps, or through the write step alone once its buffer is
// open; a stop, an unknown command or an ignored load is handled in the idle state.
module multi_voice_pcm_mixer #(
	parameter int VOICES = mvpm_pkg::VOICES_DEF,
	parameter int MAX_SAMPLES = mvpm_pkg::MAX_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // command, sample_value, gain, loop_flag, zero pad
	input  logic        s_tlast,  // last_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // mixed_sample
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_wdata
);

	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

	logic fmt_q, en_q;
	mvpm_pkg::ctl_t ctl;
	mvpm_pkg::sts_t sts;
	logic [VW-1:0] voice;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= 1'b0;
			en_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == mvpm_pkg::REG_FORMAT) fmt_q <= cfg_wdata;
			if (cfg_index == mvpm_pkg::REG_ENABLE) en_q <= cfg_wdata;
		end
	end

	mvpm_ctrl #(.VOICES(VOICES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_cmd(s_tdata[1:0]),
		.enabled(en_q), .in_ready(s_tready), .out_valid(m_tvalid),
		.out_ready(m_tready), .sts(sts), .ctl(ctl), .voice(voice)
	);

	mvpm_dp #(.VOICES(VOICES), .MAX_SAMPLES(MAX_SAMPLES)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts), .voice(voice),
		.fmt32(fmt_q), .in_sample(s_tdata[17:2]), .in_gain(s_tdata[33:18]),
		.in_loop(s_tdata[34]), .in_last(s_tlast), .result(m_tdata)
	);

	// a load step never coincides with the tick sum
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.load_write && (ctl.mix_acc || ctl.loop_acc)))
		else $error("load during mix");
	// a result is posted only by the format stage
	a_post: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(ctl.fmt_out))
		else $error("result without format");
	// no item accepted mid tick
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mix_read |-> !s_tready)
		else $error("ready during tick");

endmodule
